// ----- sv/ntc_pkg.sv -----
// ----------------------------------------------------------------------------
// ntc thermistor package
// shared types, constants and the resistance rom
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned SumW    = 20;
  localparam int unsigned CountW  = 8;
  localparam int unsigned DivW    = 17;
  localparam int unsigned ResW    = 29;
  localparam int unsigned TempW   = 8;
  localparam int unsigned RomW    = 17;
  localparam int unsigned NumW    = SampleW + DivW;

  localparam logic [ResW-1:0] ResMax = {ResW{1'b1}};

  typedef enum logic [0:0] {
    CFG_SAMPLES = 1'b0,
    CFG_DIVIDER = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_MUL,
    ST_DIV,
    ST_SRCH,
    ST_OUT
  } state_e;

  function automatic logic [RomW-1:0] ohm_rom(input logic [7:0] idx);
    logic [RomW-1:0] v;
    unique case (idx)
      8'd0: v = 17'd98260;   8'd1: v = 17'd92740;   8'd2: v = 17'd87550;
      8'd3: v = 17'd82690;   8'd4: v = 17'd78120;   8'd5: v = 17'd73830;
      8'd6: v = 17'd69800;   8'd7: v = 17'd66010;   8'd8: v = 17'd62450;
      8'd9: v = 17'd59100;   8'd10: v = 17'd55950;  8'd11: v = 17'd52980;
      8'd12: v = 17'd50190;  8'd13: v = 17'd47570;  8'd14: v = 17'd45090;
      8'd15: v = 17'd42760;  8'd16: v = 17'd40560;  8'd17: v = 17'd38490;
      8'd18: v = 17'd36530;  8'd19: v = 17'd34680;  8'd20: v = 17'd32940;
      8'd21: v = 17'd31300;  8'd22: v = 17'd29740;  8'd23: v = 17'd28280;
      8'd24: v = 17'd26890;  8'd25: v = 17'd25580;  8'd26: v = 17'd24340;
      8'd27: v = 17'd23170;  8'd28: v = 17'd22060;  8'd29: v = 17'd21010;
      8'd30: v = 17'd20010;  8'd31: v = 17'd19070;  8'd32: v = 17'd18180;
      8'd33: v = 17'd17330;  8'd34: v = 17'd16530;  8'd35: v = 17'd15770;
      8'd36: v = 17'd15050;  8'd37: v = 17'd14370;  8'd38: v = 17'd13720;
      8'd39: v = 17'd13100;  8'd40: v = 17'd12520;  8'd41: v = 17'd11960;
      8'd42: v = 17'd11430;  8'd43: v = 17'd10930;  8'd44: v = 17'd10450;
      8'd45: v = 17'd10000;  8'd46: v = 17'd9569;   8'd47: v = 17'd9158;
      8'd48: v = 17'd8768;   8'd49: v = 17'd8396;   8'd50: v = 17'd8042;
      8'd51: v = 17'd7705;   8'd52: v = 17'd7384;   8'd53: v = 17'd7078;
      8'd54: v = 17'd6786;   8'd55: v = 17'd6508;   8'd56: v = 17'd6243;
      8'd57: v = 17'd5990;   8'd58: v = 17'd5749;   8'd59: v = 17'd5519;
      8'd60: v = 17'd5299;   8'd61: v = 17'd5089;   8'd62: v = 17'd4889;
      8'd63: v = 17'd4697;   8'd64: v = 17'd4514;   8'd65: v = 17'd4339;
      8'd66: v = 17'd4172;   8'd67: v = 17'd4011;   8'd68: v = 17'd3860;
      8'd69: v = 17'd3713;   8'd70: v = 17'd3574;   8'd71: v = 17'd3440;
      8'd72: v = 17'd3312;   8'd73: v = 17'd3189;   8'd74: v = 17'd3071;
      8'd75: v = 17'd2959;   8'd76: v = 17'd2851;   8'd77: v = 17'd2748;
      8'd78: v = 17'd2649;   8'd79: v = 17'd2554;   8'd80: v = 17'd2463;
      8'd81: v = 17'd2375;   8'd82: v = 17'd2292;   8'd83: v = 17'd2211;
      8'd84: v = 17'd2134;   8'd85: v = 17'd2060;   8'd86: v = 17'd1989;
      8'd87: v = 17'd1921;   8'd88: v = 17'd1855;   8'd89: v = 17'd1792;
      8'd90: v = 17'd1731;   8'd91: v = 17'd1673;   8'd92: v = 17'd1617;
      8'd93: v = 17'd1563;   8'd94: v = 17'd1512;   8'd95: v = 17'd1462;
      8'd96: v = 17'd1414;   8'd97: v = 17'd1368;   8'd98: v = 17'd1324;
      8'd99: v = 17'd1281;   8'd100: v = 17'd1240;  8'd101: v = 17'd1201;
      8'd102: v = 17'd1163;  8'd103: v = 17'd1126;  8'd104: v = 17'd1091;
      8'd105: v = 17'd1056;  8'd106: v = 17'd1024;  8'd107: v = 17'd992;
      8'd108: v = 17'd961;   8'd109: v = 17'd932;   8'd110: v = 17'd903;
      8'd111: v = 17'd876;   8'd112: v = 17'd850;   8'd113: v = 17'd824;
      8'd114: v = 17'd800;   8'd115: v = 17'd776;   8'd116: v = 17'd753;
      8'd117: v = 17'd731;   8'd118: v = 17'd709;   8'd119: v = 17'd689;
      8'd120: v = 17'd669;   8'd121: v = 17'd650;   8'd122: v = 17'd631;
      8'd123: v = 17'd613;   8'd124: v = 17'd596;   8'd125: v = 17'd579;
      8'd126: v = 17'd563;   8'd127: v = 17'd547;   8'd128: v = 17'd532;
      8'd129: v = 17'd517;   8'd130: v = 17'd503;   8'd131: v = 17'd489;
      8'd132: v = 17'd476;   8'd133: v = 17'd463;   8'd134: v = 17'd450;
      8'd135: v = 17'd438;   8'd136: v = 17'd426;   8'd137: v = 17'd415;
      8'd138: v = 17'd404;   8'd139: v = 17'd393;   8'd140: v = 17'd383;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/ntc_thermistor_temperature.sv -----
// ----------------------------------------------------------------------------
// ntc thermistor temperature
// averages adc samples, computes thermistor resistance and looks it up
// ----------------------------------------------------------------------------
// flow: a sample that does not finish a reading is added to the sum; a finishing
//   sample sets off a pass of the shared restoring divider for the average, a
//   second pass for the resistance unless the average reaches full scale, and
//   the rom scan (one entry a cycle) that stops at rom index k, at most
//   TABLE_ENTRIES-2; the result then waits out any output stall
// input: one reading at a time, in_stall_o high while a reading is worked out
// reset: asynchronous active low, counters cleared, registers to 10 and 10000
module ntc_thermistor_temperature #(
  parameter int unsigned TABLE_ENTRIES  = 141,
  parameter int unsigned ADC_FULL_SCALE = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ntc_pkg::SampleW-1:0]  adc_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [ntc_pkg::TempW-1:0] temperature_c_o,
  output logic [ntc_pkg::ResW-1:0]     resistance_ohms_o,
  output logic [ntc_pkg::SampleW-1:0]  average_code_o,
  output logic                         below_range_o,
  output logic                         above_range_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [ntc_pkg::DivW-1:0]     cfg_data_i
);
  import ntc_pkg::*;

  localparam int unsigned FsW   = $clog2(ADC_FULL_SCALE + 1);
  localparam int unsigned DivNW = SumW > NumW ? SumW : NumW;
  localparam int unsigned IdxW  = 8;
  // scan limit: intervals i < TABLE_ENTRIES-2
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 2);

  state_e state_q, state_d;

  logic [CountW-1:0]  spr_q;
  logic [DivW-1:0]    div_ohm_q;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [CountW-1:0]  taken_q, taken_d;
  logic [SampleW-1:0] avg_q, avg_d;
  logic [ResW-1:0]    res_q, res_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [TempW-1:0]   temp_q, temp_d;
  logic               below_q, below_d, above_q, above_d;
  logic               out_valid_q, out_valid_d;

  // shared divider request
  logic               dv_start;
  logic [DivNW-1:0]   dv_num;
  logic [DivW-1:0]    dv_den;
  logic               dv_done;
  logic [DivNW-1:0]   dv_quot;

  logic               in_acc;
  logic [CountW-1:0]  n_eff;
  logic [SumW-1:0]    sum_new;
  logic [CountW-1:0]  taken_new;
  logic [NumW-1:0]    product;
  logic [FsW-1:0]     headroom;
  logic [RomW-1:0]    rom_hi, rom_lo;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign n_eff       = (spr_q == '0) ? CountW'(1) : spr_q;
  assign sum_new     = sum_q + SumW'(adc_sample_i);
  assign taken_new   = taken_q + 1'b1;
  assign product     = NumW'(avg_q) * NumW'(div_ohm_q);
  assign headroom    = FsW'(ADC_FULL_SCALE) - FsW'(avg_q);
  assign rom_hi      = ohm_rom(idx_q);
  assign rom_lo      = ohm_rom(idx_q + 1'b1);

  ntc_divider #(
    .NumW (DivNW),
    .DenW (DivW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .done_o  (dv_done),
    .quot_o  (dv_quot)
  );

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    taken_d     = taken_q;
    avg_d       = avg_q;
    res_d       = res_q;
    idx_d       = idx_q;
    temp_d      = temp_q;
    below_d     = below_q;
    above_d     = above_q;
    out_valid_d = out_valid_q;
    dv_start    = 1'b0;
    dv_num      = DivNW'(sum_new);
    dv_den      = DivW'(n_eff);
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (taken_new < n_eff) begin
            sum_d   = sum_new;
            taken_d = taken_new;
          end else begin
            // reading complete: divide the sum by the count
            sum_d    = '0;
            taken_d  = '0;
            dv_start = 1'b1;
            state_d  = ST_AVG;
          end
        end
      end
      ST_AVG: begin
        if (dv_done) begin
          avg_d   = dv_quot[SampleW-1:0];
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (32'(avg_q) >= 32'(ADC_FULL_SCALE)) begin
          res_d   = ResMax;
          idx_d   = '0;
          state_d = ST_SRCH;
        end else begin
          dv_num   = DivNW'(product);
          dv_den   = DivW'(headroom);
          dv_start = 1'b1;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dv_done) begin
          res_d   = dv_quot[ResW-1:0];
          idx_d   = '0;
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        below_d = 1'b0;
        above_d = 1'b0;
        if (idx_q == '0 && res_q > ResW'(rom_hi)) begin
          below_d = 1'b1;
          temp_d  = -TempW'(20);
          state_d = ST_OUT;
        end else if (idx_q >= LastIdx) begin
          above_d = 1'b1;
          temp_d  = TempW'(120);
          state_d = ST_OUT;
        end else if (res_q <= ResW'(rom_hi) && res_q >= ResW'(rom_lo)) begin
          temp_d  = TempW'(idx_q) - TempW'(20);
          state_d = ST_OUT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_OUT: begin
        // wait until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      spr_q       <= CountW'(10);
      div_ohm_q   <= DivW'(10000);
      sum_q       <= '0;
      taken_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      taken_q     <= taken_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_SAMPLES: spr_q     <= cfg_data_i[CountW-1:0];
          CFG_DIVIDER: div_ohm_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q   <= avg_d;
    res_q   <= res_d;
    idx_q   <= idx_d;
    temp_q  <= temp_d;
    below_q <= below_d;
    above_q <= above_d;
  end

  // output register loads in ST_OUT once it is free and holds its value otherwise
  logic [TempW-1:0]   o_temp_q;
  logic [ResW-1:0]    o_res_q;
  logic [SampleW-1:0] o_avg_q;
  logic               o_below_q, o_above_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
      o_temp_q  <= temp_q;
      o_res_q   <= res_q;
      o_avg_q   <= avg_q;
      o_below_q <= below_q;
      o_above_q <= above_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign temperature_c_o   = $signed(o_temp_q);
  assign resistance_ohms_o = o_res_q;
  assign average_code_o    = o_avg_q;
  assign below_range_o     = o_below_q;
  assign above_range_o     = o_above_q;

  // no sample accepted while a reading is worked out
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_acc)
    else $error("sample accepted while busy");

  // flags are exclusive
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(o_below_q && o_above_q))
    else $error("both range flags set");

  // a stalled result is held
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(o_res_q)))
    else $error("stalled result changed");

  // accumulation count is cleared while a reading is worked out
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (taken_q == '0))
    else $error("count not cleared on reading");

endmodule

// ----- sv/ntc_divider.sv -----
// ----------------------------------------------------------------------------
// ntc restoring divider
// unsigned radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ntc_divider #(
  parameter int unsigned NumW = 29,
  parameter int unsigned DenW = 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[NumW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in next numerator bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d  = DenW'(trial - {1'b0, den_q});
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial[DenW-1:0];
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
